>>> rtl/core/txr_pkg.sv
// ============================================================================
// txr_pkg
// Shared widths, codes and types for the transmit ring chunk scheduler.
// ============================================================================
package txr_pkg;

   localparam int RING_DEPTH = 256;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 10;
   localparam int ACT_W      = 2;
   localparam int STAT_W     = 2;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // item actions
   localparam logic [ACT_W-1:0] ACT_BEGIN = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DATA  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DONE  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_FETCH = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_PARAM   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NO_OPEN = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              chunk_start;
      idx_type           chunk_index;
      idx_type           chunk_len;
      byte_type          fetched_byte;
      idx_type           free_space;
   } rsp_type;

endpackage

>>> rtl/core/txr_channels.sv
// ============================================================================
// txr_channels
// Valid/ready channels for the request and response items.
// ============================================================================
interface txr_req_if;
   logic                        valid;
   logic                        ready;
   logic [txr_pkg::ACT_W-1:0]   action;
   logic [txr_pkg::LEN_W-1:0]   msg_len;
   logic [txr_pkg::BYTE_W-1:0]  data_byte;
   logic [txr_pkg::IDX_W-1:0]   fetch_index;

   modport source (output valid, action, msg_len, data_byte, fetch_index, input ready);
   modport sink   (input valid, action, msg_len, data_byte, fetch_index, output ready);
endinterface

interface txr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [txr_pkg::STAT_W-1:0]  status;
   logic                        chunk_start;
   logic [txr_pkg::IDX_W-1:0]   chunk_index;
   logic [txr_pkg::IDX_W-1:0]   chunk_len;
   logic [txr_pkg::BYTE_W-1:0]  fetched_byte;
   logic [txr_pkg::IDX_W-1:0]   free_space;

   modport source (output valid, status, chunk_start, chunk_index, chunk_len,
                   fetched_byte, free_space, input ready);
   modport sink   (input valid, status, chunk_start, chunk_index, chunk_len,
                   fetched_byte, free_space, output ready);
endinterface

>>> rtl/core/txr_ring_ram.sv
// ============================================================================
// txr_ring_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module txr_ring_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tx_ring_dma_chunk_scheduler_core.sv
// ============================================================================
// tx_ring_dma_chunk_scheduler_core
// Transmit byte ring with all-or-nothing message admission and DMA chunking.
// ============================================================================
// Begin, data and dma-done items are accepted whenever no fetch read is
// pending and the output register is empty or is being drained in the same
// cycle, and their result sits in the output register at the next edge. A
// fetch item waits in a pending register for the ring RAM read, then moves
// with the read byte into the output register once it is free; the request
// side stalls in the read state. Ring contents come up undefined after reset
// and need no clearing pass; pointers, message and chunk state reset to
// empty. Data bytes are written at accept, so a later fetch always sees them.
// Every item returns exactly one result; a DMA chunk is issued in the result
// of any item that leaves the engine idle with bytes queued.
// ============================================================================
module tx_ring_dma_chunk_scheduler_core (
   input  logic      clock,
   input  logic      reset,
   txr_req_if.sink   req_chan,
   txr_rsp_if.source rsp_chan
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;

   // pointer and message state
   txr_pkg::idx_type head_ff,     head_in;
   txr_pkg::idx_type tail_ff,     tail_in;
   txr_pkg::idx_type wr_idx_ff,   wr_idx_in;
   txr_pkg::idx_type remain_ff,   remain_in;
   txr_pkg::idx_type open_len_ff, open_len_in;
   txr_pkg::idx_type infl_len_ff, infl_len_in;
   logic             busy_ff,     busy_in;

   // result staging
   txr_pkg::rsp_type pend_ff, pend_in;     // fetch result awaiting RAM data
   txr_pkg::rsp_type rsp_ff,  rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             req_accept;
   logic             slot_free;
   logic             ram_we;
   logic             ram_re;
   txr_pkg::byte_type ram_rdata;
   txr_pkg::rsp_type  res;
   txr_pkg::idx_type  count_now;
   txr_pkg::idx_type  free_now;

   txr_ring_ram #(
      .DEPTH (txr_pkg::RING_DEPTH),
      .WIDTH (txr_pkg::BYTE_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (req_chan.data_byte),
      .rd_en   (ram_re),
      .rd_addr (req_chan.fetch_index),
      .rd_data (ram_rdata)
   );

   // output register may take a new result this cycle
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // queued bytes wrap modulo the ring size; one slot always kept empty
   assign count_now = head_ff - tail_ff;
   assign free_now  = ~count_now;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      wr_idx_in   = wr_idx_ff;
      remain_in   = remain_ff;
      open_len_in = open_len_ff;
      infl_len_in = infl_len_ff;
      busy_in     = busy_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      res         = '0;

      unique case (req_chan.action)
         txr_pkg::ACT_BEGIN: begin
            if (req_chan.msg_len == '0) begin
               res.status = txr_pkg::STAT_PARAM;
            end else if (req_chan.msg_len >
                         {{(txr_pkg::LEN_W-txr_pkg::IDX_W){1'b0}}, free_now}) begin
               res.status = txr_pkg::STAT_FULL;
            end else begin
               // admitted: any open message is abandoned
               wr_idx_in   = head_ff;
               remain_in   = req_chan.msg_len[txr_pkg::IDX_W-1:0];
               open_len_in = req_chan.msg_len[txr_pkg::IDX_W-1:0];
            end
         end
         txr_pkg::ACT_DATA: begin
            if (remain_ff == '0) begin
               res.status = txr_pkg::STAT_NO_OPEN;
            end else begin
               ram_we    = req_accept;
               wr_idx_in = wr_idx_ff + 1'b1;
               remain_in = remain_ff - 1'b1;
               if (remain_ff == txr_pkg::IDX_W'(1)) begin
                  // last byte commits the whole message
                  head_in     = head_ff + open_len_ff;
                  open_len_in = '0;
               end
            end
         end
         txr_pkg::ACT_DONE: begin
            if (busy_ff) begin
               tail_in     = tail_ff + infl_len_ff;
               infl_len_in = '0;
               busy_in     = 1'b0;
            end
         end
         txr_pkg::ACT_FETCH: begin
            ram_re = req_accept;
         end
         default: begin
         end
      endcase

      // chunk issue on the post-action state
      if (!busy_in && (head_in != tail_in)) begin
         res.chunk_start = 1'b1;
         res.chunk_index = tail_in;
         // up to the head, or up to the end of the ring on wrap
         res.chunk_len   = (head_in > tail_in) ? (head_in - tail_in) : (~tail_in + 1'b1);
         infl_len_in     = res.chunk_len;
         busy_in         = 1'b1;
      end

      res.free_space = ~(head_in - tail_in);
   end

   // result path: fetch results wait in the pending register for the RAM read
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.action == txr_pkg::ACT_FETCH) begin
                  pend_in  = res;
                  state_in = ST_READ;
               end else begin
                  rsp_in       = res;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            if (slot_free) begin
               rsp_in              = pend_ff;
               rsp_in.fetched_byte = ram_rdata;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         wr_idx_ff    <= '0;
         remain_ff    <= '0;
         open_len_ff  <= '0;
         infl_len_ff  <= '0;
         busy_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            wr_idx_ff   <= wr_idx_in;
            remain_ff   <= remain_in;
            open_len_ff <= open_len_in;
            infl_len_ff <= infl_len_in;
            busy_ff     <= busy_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_ff.status;
   assign rsp_chan.chunk_start  = rsp_ff.chunk_start;
   assign rsp_chan.chunk_index  = rsp_ff.chunk_index;
   assign rsp_chan.chunk_len    = rsp_ff.chunk_len;
   assign rsp_chan.fetched_byte = rsp_ff.fetched_byte;
   assign rsp_chan.free_space   = rsp_ff.free_space;

endmodule

>>> sim/tx_ring_dma_chunk_scheduler_core_tb.sv
// ============================================================================
// tx_ring_dma_chunk_scheduler_core_tb
// Self-checking bench for the transmit ring chunk scheduler. Each item is
// predicted against a shadow copy of the ring, its pointers, the open message
// and the DMA chunk state. Every response item is checked field by field, in
// order, with random idling on both channels and two pressure phases.
// ============================================================================
module tx_ring_dma_chunk_scheduler_core_tb;
   import txr_pkg::*;

   localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either channel
   localparam int HOLD_CYCLES = 300;    // long response hold-off
   localparam int TAIL_CYCLES = 8;      // settle time after the last response

   logic clock = 1'b0;
   logic reset;

   txr_req_if req_if ();
   txr_rsp_if rsp_if ();

   tx_ring_dma_chunk_scheduler_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow ring state
   // ------------------------------------------------------------------------
   byte_type    ring_mem [RING_DEPTH];
   bit          slot_seen [RING_DEPTH];   // slot has been written at least once
   int unsigned seen_total;
   idx_type     head_ptr;
   idx_type     tail_ptr;
   idx_type     wr_ptr;
   int unsigned bytes_due;                // 0 means no message open
   int unsigned msg_total;
   int unsigned inflight_len;
   bit          chunk_busy;

   rsp_type     rsp_expect_q [$];
   int unsigned fail_count;
   int unsigned quiet_cycles;

   // idling controls, percent of cycles
   int unsigned snd_idle_pct;
   int unsigned rcv_idle_pct;
   int unsigned rsp_hold;                 // remaining forced-stall cycles

   // free slots: one slot is always kept empty
   function automatic int unsigned ring_room();
      idx_type used;
      used = head_ptr - tail_ptr;
      return (RING_DEPTH - 1) - int'(used);
   endfunction

   // Applies one item to the shadow state and returns its response.
   function automatic rsp_type ring_predict(input logic [ACT_W-1:0] act,
                                            input logic [LEN_W-1:0] len,
                                            input byte_type data,
                                            input idx_type fidx);
      rsp_type     r;
      int unsigned clen;
      r = '0;
      case (act)
         ACT_BEGIN: begin
            if (len == '0) begin
               r.status = STAT_PARAM;
            end else if (int'(len) > ring_room()) begin
               r.status = STAT_FULL;      // open message, if any, survives
            end else begin
               // abandons any open message; writing restarts at head
               wr_ptr    = head_ptr;
               bytes_due = len;
               msg_total = len;
            end
         end
         ACT_DATA: begin
            if (bytes_due == 0) begin
               r.status = STAT_NO_OPEN;
            end else begin
               ring_mem[wr_ptr] = data;
               if (!slot_seen[wr_ptr]) begin
                  slot_seen[wr_ptr] = 1'b1;
                  seen_total++;
               end
               wr_ptr++;
               bytes_due--;
               if (bytes_due == 0) begin
                  head_ptr  = head_ptr + idx_type'(msg_total);
                  msg_total = 0;
               end
            end
         end
         ACT_DONE: begin
            // done with no chunk in flight is ignored
            if (chunk_busy) begin
               tail_ptr     = tail_ptr + idx_type'(inflight_len);
               inflight_len = 0;
               chunk_busy   = 1'b0;
            end
         end
         default: begin
            r.fetched_byte = ring_mem[fidx];
         end
      endcase

      // chunk issue is checked after every action, the freeing done included
      if (!chunk_busy && head_ptr != tail_ptr) begin
         if (head_ptr > tail_ptr) clen = int'(head_ptr) - int'(tail_ptr);
         else clen = RING_DEPTH - int'(tail_ptr);   // stop at the wrap
         r.chunk_start = 1'b1;
         r.chunk_index = tail_ptr;
         r.chunk_len   = idx_type'(clen);
         inflight_len  = clen;
         chunk_busy    = 1'b1;
      end
      r.free_space = idx_type'(ring_room());
      return r;
   endfunction

   // a slot that already holds a byte; caller makes sure one exists
   function automatic idx_type pick_written_slot();
      idx_type slot;
      do slot = idx_type'($urandom_range(RING_DEPTH - 1));
      while (!slot_seen[slot]);
      return slot;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Called at a falling edge, returns at a falling edge with
   // valid still high so back-to-back items need no extra drop.
   // ------------------------------------------------------------------------
   task automatic send_item(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] len,
                            input byte_type data, input idx_type fidx);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.msg_len     <= len;
      req_if.data_byte   <= data;
      req_if.fetch_index <= fidx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      rsp_expect_q.push_back(ring_predict(act, len, data, fidx));
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_all_responses();
      while (rsp_expect_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly well-formed traffic: a begin with a legal length followed by its
   // bytes, with done and fetch items mixed in; a few items are noise.
   task automatic send_random_item();
      int unsigned      sel;
      int unsigned      room;
      logic [LEN_W-1:0] len;
      byte_type         data;
      idx_type          fidx;
      sel  = $urandom_range(99);
      room = ring_room();
      data = byte_type'($urandom_range(255));
      fidx = idx_type'($urandom_range(RING_DEPTH - 1));
      if (sel < 6) begin
         // noise: any action with loose fields
         case ($urandom_range(3))
            0: begin
               len = ($urandom_range(3) == 0) ? '0 : LEN_W'($urandom_range(1023));
               send_item(ACT_BEGIN, len, data, fidx);
            end
            1: send_item(ACT_DATA, LEN_W'($urandom_range(1023)), data, fidx);
            2: send_item(ACT_DONE, LEN_W'($urandom_range(1023)), data, fidx);
            default: begin
               if (seen_total != 0) fidx = pick_written_slot();
               send_item(seen_total != 0 ? ACT_FETCH : ACT_DONE,
                         LEN_W'($urandom_range(1023)), data, fidx);
            end
         endcase
      end else if (sel < 20) begin
         send_item(ACT_DONE, LEN_W'($urandom_range(1023)), data, fidx);
      end else if (sel < 28 && seen_total != 0) begin
         send_item(ACT_FETCH, LEN_W'($urandom_range(1023)), data, pick_written_slot());
      end else if (bytes_due != 0 && sel < 97) begin
         send_item(ACT_DATA, LEN_W'($urandom_range(1023)), data, fidx);
      end else begin
         if (room == 0) begin
            len = LEN_W'($urandom_range(1023, 1));
         end else if ($urandom_range(4) != 0) begin
            len = LEN_W'($urandom_range(room < 24 ? room : 24, 1));
         end else begin
            len = LEN_W'($urandom_range(room, 1));
         end
         send_item(ACT_BEGIN, len, data, fidx);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_cases();
      send_item(ACT_BEGIN, 10'd0,    8'h3C, 8'h00);   // zero length
      send_item(ACT_BEGIN, 10'd1023, 8'hC3, 8'hFF);   // far too long
      send_item(ACT_BEGIN, 10'd256,  8'h00, 8'h55);   // one over the free space
      send_item(ACT_DATA,  10'd0,    8'hFF, 8'hAA);   // no open message
      send_item(ACT_DONE,  10'd0,    8'h00, 8'h00);   // no chunk in flight
      send_item(ACT_BEGIN, 10'd255,  8'h00, 8'h00);   // exactly the free space
      send_item(ACT_DATA,  10'd0,    8'h77, 8'h00);   // byte of a message to be dropped
      send_item(ACT_BEGIN, 10'd3,    8'h00, 8'h00);   // abandons the open message
      send_item(ACT_DATA,  10'd0,    8'h00, 8'h00);
      send_item(ACT_DATA,  10'd0,    8'hFF, 8'h00);
      send_item(ACT_DATA,  10'd0,    8'h5A, 8'h00);   // commit, chunk issued
      send_item(ACT_BEGIN, 10'd4,    8'h00, 8'h00);
      send_item(ACT_DATA,  10'd0,    8'hA5, 8'h00);
      send_item(ACT_BEGIN, 10'd1000, 8'h00, 8'h00);   // too long while open
      send_item(ACT_DATA,  10'd0,    8'h81, 8'h00);
      send_item(ACT_DATA,  10'd0,    8'h7E, 8'h00);
      send_item(ACT_DATA,  10'd0,    8'h01, 8'h00);   // commit while busy
      send_item(ACT_FETCH, 10'd0,    8'h00, 8'h00);
      send_item(ACT_FETCH, 10'd0,    8'h00, 8'h01);
      send_item(ACT_FETCH, 10'd0,    8'h00, 8'h06);
      send_item(ACT_DONE,  10'd0,    8'h00, 8'h00);   // retire, next chunk same item
      send_item(ACT_DONE,  10'd0,    8'h00, 8'h00);   // ring drained
      send_item(ACT_DATA,  10'd0,    8'h00, 8'h00);   // nothing open any more
   endtask

   task automatic test_random_traffic(input int unsigned count);
      repeat (count) send_random_item();
   endtask

   // Hold the response side off while items keep coming, so the block
   // backs up and stalls its request side.
   task automatic test_backpressure();
      int unsigned saved_pct;
      saved_pct = snd_idle_pct;
      idle_sender();
      @(posedge clock);
      rsp_hold = HOLD_CYCLES;
      @(negedge clock);
      snd_idle_pct = 0;
      repeat (40) send_random_item();
      snd_idle_pct = saved_pct;
   endtask

   // Sender goes quiet until every response is back, then resumes.
   task automatic test_drain_pause();
      repeat (30) send_random_item();
      idle_sender();
      wait_all_responses();
      repeat (30) send_random_item();
   endtask

   // ------------------------------------------------------------------------
   // Response side: random ready, with an optional long hold-off
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rsp_expect_q.size() == 0) begin
            $error("response item with no request outstanding");
            fail_count++;
         end else begin
            want = rsp_expect_q.pop_front();
            check_field("status",       want.status,       rsp_if.status);
            check_field("chunk_start",  want.chunk_start,  rsp_if.chunk_start);
            check_field("chunk_index",  want.chunk_index,  rsp_if.chunk_index);
            check_field("chunk_len",    want.chunk_len,    rsp_if.chunk_len);
            check_field("fetched_byte", want.fetched_byte, rsp_if.fetched_byte);
            check_field("free_space",   want.free_space,   rsp_if.free_space);
         end
      end
   end

   // watchdog: a long run of cycles with no item moving means a hang
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.action      = ACT_BEGIN;
      req_if.msg_len     = '0;
      req_if.data_byte   = '0;
      req_if.fetch_index = '0;
      rsp_if.ready       = 1'b0;
      quiet_cycles       = 0;
      fail_count         = 0;
      rsp_hold           = 0;
      head_ptr           = '0;
      tail_ptr           = '0;
      wr_ptr             = '0;
      bytes_due          = 0;
      msg_total          = 0;
      inflight_len       = 0;
      chunk_busy         = 1'b0;
      seen_total         = 0;
      foreach (slot_seen[i]) slot_seen[i] = 1'b0;
      foreach (ring_mem[i]) ring_mem[i] = '0;

      // first phase: sender idles lightly, receiver heavily
      snd_idle_pct = 38;
      rcv_idle_pct = 64;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_traffic(360);
      test_backpressure();

      // second phase: roles swapped
      snd_idle_pct = 64;
      rcv_idle_pct = 38;
      test_random_traffic(360);
      test_drain_pause();

      // last phase: full rate both ways
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_traffic(360);

      idle_sender();
      wait_all_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
